@@ rtl/pwlti_pkg.sv @@
// Shared types, field widths and codes for the piecewise linear table interpolator.
package pwlti_pkg;

    localparam int TIME_W    = 16;
    localparam int HEIGHT_W  = 32;
    localparam int SLOT_W    = 6;
    localparam int CFG_W     = 7;
    localparam int STAT_W    = 2;
    localparam int PROD_W    = TIME_W + HEIGHT_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_EXACT  = 2'd0;
    localparam logic [STAT_W-1:0] ST_INTERP = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_LOADED = 2'd3;

    // time table read address select
    localparam logic [1:0] T_ZERO = 2'd0;
    localparam logic [1:0] T_LAST = 2'd1;
    localparam logic [1:0] T_NEXT = 2'd2;

    // height table read address select
    localparam logic H_PICK = 1'b0;
    localparam logic H_NEXT = 1'b1;

    typedef struct packed {
        logic              cap_q;
        logic              ld_we;
        logic              cap_first;
        logic              scan_init;
        logic              scan_step;
        logic              cap_h0;
        logic              cap_dh;
        logic              mul;
        logic              div_step;
        logic              set_res;
        logic [STAT_W-1:0] res_stat;
        logic              out_load;
        logic [1:0]        t_sel;
        logic              h_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic oor;
        logic hit;
        logic scan_last;
        logic div_last;
    } t_dp_stat;

endpackage

@@ rtl/pwlti_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pwlti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pwlti_dp.sv @@
// Datapath: breakpoint tables, scan, multiplier, serial divider and result registers.
module pwlti_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pwlti_pkg::t_dp_cmd                    i_cmd,
    output pwlti_pkg::t_dp_stat                   o_stat,
    input  logic                                  i_cfg_we,
    input  logic [pwlti_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [pwlti_pkg::SLOT_W-1:0]          i_point_slot,
    input  logic [pwlti_pkg::TIME_W-1:0]          i_point_time,
    input  logic signed [pwlti_pkg::HEIGHT_W-1:0] i_point_height,
    input  logic [pwlti_pkg::TIME_W-1:0]          i_query_time,
    output logic signed [pwlti_pkg::HEIGHT_W-1:0] o_height_out,
    output logic [pwlti_pkg::STAT_W-1:0]          o_status
);
    import pwlti_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CFG_W-1:0]    r_cfg;
    logic [CW-1:0]       used;
    logic [AW-1:0]       last_idx;

    logic                ld_en;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       t_raddr;
    logic [AW-1:0]       h_raddr;
    logic [TIME_W-1:0]   t_rd;
    logic [HEIGHT_W-1:0] h_rd;

    logic [TIME_W-1:0]   r_q;
    logic [TIME_W-1:0]   r_t_first;
    logic [AW-1:0]       r_rd_idx;
    logic                r_hit;
    logic                r_stop;
    logic [AW-1:0]       r_hit_idx;
    logic [AW-1:0]       r_lo;
    logic [TIME_W-1:0]   r_t0;
    logic [TIME_W-1:0]   r_t1;
    logic [HEIGHT_W-1:0] r_h0;
    logic                r_neg;
    logic [HEIGHT_W-1:0] r_dmag;
    logic [PROD_W-1:0]   r_num;
    logic [TIME_W-1:0]   r_den;
    logic [TIME_W-1:0]   r_rem;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [HEIGHT_W-1:0] r_res;
    logic [STAT_W-1:0]   r_stat;
    logic [HEIGHT_W-1:0] r_height_out;
    logic [STAT_W-1:0]   r_status;

    logic                hit_now;
    logic [HEIGHT_W:0]   diff;
    logic [HEIGHT_W:0]   ndiff;
    logic [TIME_W-1:0]   dt;
    logic [PROD_W-1:0]   prod;
    logic [TIME_W:0]     rem_sh;
    logic [TIME_W:0]     rem_sub;
    logic                ge;
    logic [HEIGHT_W+1:0] sq;
    logic [HEIGHT_W+1:0] sum;

    // clamp the configured count into [2, MAX_POINTS]
    always_comb begin
        if (int'(r_cfg) < 2) begin
            used = CW'(2);
        end else if (int'(r_cfg) > MAX_POINTS) begin
            used = CW'(MAX_POINTS);
        end else begin
            used = CW'(r_cfg);
        end
    end
    assign last_idx = AW'(used - CW'(1));

    assign ld_en = i_cmd.ld_we && (int'(i_point_slot) < MAX_POINTS);
    assign waddr = AW'(i_point_slot);

    always_comb begin
        case (i_cmd.t_sel)
            T_ZERO:  t_raddr = '0;
            T_LAST:  t_raddr = last_idx;
            T_NEXT:  t_raddr = r_rd_idx + AW'(1);
            default: t_raddr = '0;
        endcase
    end

    assign h_raddr = (i_cmd.h_sel == H_NEXT) ? r_lo + AW'(1) : (r_hit ? r_hit_idx : r_lo);

    pwlti_ram #(.WIDTH(TIME_W), .DEPTH(MAX_POINTS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ld_en),
        .i_waddr (waddr),
        .i_wdata (i_point_time),
        .i_raddr (t_raddr),
        .o_rdata (t_rd)
    );

    pwlti_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_POINTS)) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (ld_en),
        .i_waddr (waddr),
        .i_wdata (i_point_height),
        .i_raddr (h_raddr),
        .o_rdata (h_rd)
    );

    assign hit_now = (t_rd == r_q);
    assign diff    = {h_rd[HEIGHT_W-1], h_rd} - {r_h0[HEIGHT_W-1], r_h0};
    assign ndiff   = -diff;
    assign dt      = r_q - r_t0;
    assign prod    = r_dmag * dt;
    assign rem_sh  = {r_rem, r_num[PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign sq      = r_neg ? -{2'b00, r_num[HEIGHT_W-1:0]} : {2'b00, r_num[HEIGHT_W-1:0]};
    assign sum     = {{2{r_h0[HEIGHT_W-1]}}, r_h0} + sq;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_hit  <= 1'b0;
            r_stop <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.scan_init) begin
                r_hit  <= 1'b0;
                r_stop <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (!(t_rd < r_q)) begin
                    r_stop <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_q) begin
            r_q <= i_query_time;
        end
        if (i_cmd.cap_first) begin
            r_t_first <= t_rd;
        end
        if (i_cmd.scan_init) begin
            r_rd_idx <= '0;
            r_lo     <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd_idx <= r_rd_idx + AW'(1);
            // keep the lowest matching slot
            if (hit_now && !r_hit) begin
                r_hit_idx <= r_rd_idx;
            end
            if (!r_stop) begin
                if (t_rd < r_q) begin
                    r_lo <= r_rd_idx;
                    r_t0 <= t_rd;
                end else begin
                    r_t1 <= t_rd;
                end
            end
        end
        if (i_cmd.cap_h0) begin
            r_h0 <= h_rd;
        end
        if (i_cmd.cap_dh) begin
            r_neg  <= diff[HEIGHT_W];
            r_dmag <= diff[HEIGHT_W] ? ndiff[HEIGHT_W-1:0] : diff[HEIGHT_W-1:0];
        end
        if (i_cmd.mul) begin
            r_num  <= prod;
            r_den  <= r_t1 - r_t0;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            r_rem  <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_num  <= {r_num[PROD_W-2:0], ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.set_res) begin
            r_stat <= i_cmd.res_stat;
            case (i_cmd.res_stat)
                ST_EXACT:  r_res <= h_rd;
                ST_INTERP: r_res <= sum[HEIGHT_W-1:0];
                default:   r_res <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_height_out <= r_res;
            r_status     <= r_stat;
        end
    end

    assign o_stat.oor       = (r_q < r_t_first) || (r_q > t_rd);
    assign o_stat.hit       = r_hit;
    assign o_stat.scan_last = (r_rd_idx == last_idx);
    assign o_stat.div_last  = (r_dcnt == DCNT_W'(DIV_STEPS - 1));

    assign o_height_out = r_height_out;
    assign o_status     = r_status;

endmodule

@@ rtl/pwlti_ctrl.sv @@
// Controller: sequences table reads, scan, multiply, divide and result handoff.
module pwlti_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  pwlti_pkg::t_dp_stat i_stat,
    output pwlti_pkg::t_dp_cmd  o_cmd
);
    import pwlti_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDL  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_EXH  = 4'd5;
    localparam logic [3:0] S_H0   = 4'd6;
    localparam logic [3:0] S_H1   = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_POST = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                cmd.t_sel = T_ZERO;
                if (i_in_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        cmd.ld_we    = 1'b1;
                        cmd.set_res  = 1'b1;
                        cmd.res_stat = ST_LOADED;
                        n_state      = S_POST;
                    end else begin
                        cmd.cap_q = 1'b1;
                        n_state   = S_RDL;
                    end
                end
            end
            S_RDL: begin
                cmd.cap_first = 1'b1;
                cmd.t_sel     = T_LAST;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_stat.oor) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_stat = ST_RANGE;
                    n_state      = S_POST;
                end else begin
                    cmd.scan_init = 1'b1;
                    cmd.t_sel     = T_ZERO;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.t_sel     = T_NEXT;
                if (i_stat.scan_last) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                cmd.h_sel = H_PICK;
                n_state   = i_stat.hit ? S_EXH : S_H0;
            end
            S_EXH: begin
                cmd.set_res  = 1'b1;
                cmd.res_stat = ST_EXACT;
                n_state      = S_POST;
            end
            S_H0: begin
                cmd.cap_h0 = 1'b1;
                cmd.h_sel  = H_NEXT;
                n_state    = S_H1;
            end
            S_H1: begin
                cmd.cap_dh = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.set_res  = 1'b1;
                cmd.res_stat = ST_INTERP;
                n_state      = S_POST;
            end
            S_POST: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

@@ rtl/piecewise_linear_table_interp_core.sv @@
// Top level of the piecewise linear breakpoint table interpolator.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready  | req_type, point_slot, point_time,
//           |                          | point_height, query_time
//  out      | o_out_valid / i_out_ready| height_out, status
//  cfg      | i_cfg_we (no wait)       | i_cfg_wdata = points_in_use
//
//  One item at a time. A load goes straight to the handoff; an out-of-range query
//  ends at the range check, an exact match after the scan, an interpolated query
//  after scan, multiply and divide. The scan reads one time entry per cycle from
//  the time RAM read port, and the divider retires one quotient bit per cycle.
//  Synchronous active-low reset clears the controller and sets points_in_use to 2;
//  the tables are undefined until loaded. A stalled output holds the finished item
//  while the next item is accepted and worked on.
module piecewise_linear_table_interp_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [0:0]                            i_req_type,
    input  logic [pwlti_pkg::SLOT_W-1:0]          i_point_slot,
    input  logic [pwlti_pkg::TIME_W-1:0]          i_point_time,
    input  logic signed [pwlti_pkg::HEIGHT_W-1:0] i_point_height,
    input  logic [pwlti_pkg::TIME_W-1:0]          i_query_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pwlti_pkg::HEIGHT_W-1:0] o_height_out,
    output logic [pwlti_pkg::STAT_W-1:0]          o_status,
    input  logic                                  i_cfg_we,
    input  logic [pwlti_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import pwlti_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pwlti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type[0]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pwlti_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_point_slot   (i_point_slot),
        .i_point_time   (i_point_time),
        .i_point_height (i_point_height),
        .i_query_time   (i_query_time),
        .o_height_out   (o_height_out),
        .o_status       (o_status)
    );

    // one item in flight: an accepted item closes the input until its result is posted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is still at work");

    // a result is posted only from the handoff step, never straight from idle
    a_post_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result posted without an item at work");

    // load and out-of-range results carry a zero height
    a_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_RANGE || o_status == ST_LOADED))
            |-> (o_height_out == '0))
        else $error("nonzero height on a load or out-of-range item");

endmodule
